// ===== hw/rtl/deq_pkg.sv =====
// shared constants, codes and types for the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;
  localparam int OPW   = 3;
  localparam int PW    = 6;
  localparam int SW    = 2;

  localparam int IN_BITS   = OPW + WW + PW;
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 3 * WW + CW + SW;
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OPW-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPW-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPW-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OPW-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPW-1:0] OP_READ       = 3'd4;

  typedef enum logic [SW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } deq_status_t;

  // write and read ports for one step
  typedef struct packed {
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [WW-1:0] wdata;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        faddr;
    logic [AW-1:0]        baddr;
  } deq_mem_req_t;

  // per-word information carried alongside the read data
  typedef struct packed {
    deq_status_t   status;
    logic [CW-1:0] count;
    logic          rd_ok;
    logic          nonempty;
  } deq_meta_t;

endpackage

// ===== hw/rtl/deq_ctrl.sv =====
// pointer and count state, next-state logic and stage-one info register
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 adv,
  input  logic [OPW-1:0]       operation,
  input  logic signed [WW-1:0] item_value,
  input  logic [PW-1:0]        item_position,
  output deq_mem_req_t         req,
  output deq_meta_t            meta,
  output logic                 s1_valid
);

  logic [AW-1:0] front_ptr, front_ptr_next;
  logic [CW-1:0] count, count_next;
  deq_status_t   status;
  logic          rd_ok;

  always_comb begin
    front_ptr_next = front_ptr;
    count_next     = count;
    status         = ST_OK;
    rd_ok          = 1'b0;
    req.we         = 1'b0;
    req.waddr      = front_ptr + count[AW-1:0];
    req.wdata      = item_value;
    req.raddr      = front_ptr + AW'(item_position);
    unique case (operation)
      OP_PUSH_BACK: begin
        if (count == CW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          req.we     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (count == CW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          front_ptr_next = front_ptr - AW'(1);
          req.we         = 1'b1;
          req.waddr      = front_ptr - AW'(1);
          count_next     = count + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          front_ptr_next = front_ptr + AW'(1);
          count_next     = count - CW'(1);
        end
      end
      OP_READ: begin
        if (CW'(item_position) >= count) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    req.faddr = front_ptr_next;
    req.baddr = front_ptr_next + count_next[AW-1:0] - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        front_ptr <= front_ptr_next;
        count     <= count_next;
        s1_valid  <= 1'b1;
      end else if (adv) begin
        s1_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta.status   <= status;
      meta.count    <= count_next;
      meta.rd_ok    <= rd_ok;
      meta.nonempty <= (count_next != '0);
    end
  end

endmodule

// ===== hw/rtl/deq_store.sv =====
// entry storage, two copies for three read addresses, with write bypass
`timescale 1ns / 1ps

module deq_store import deq_pkg::*; (
  input  logic                 clk,
  input  logic                 accept,
  input  deq_mem_req_t         req,
  output logic signed [WW-1:0] read_word,
  output logic signed [WW-1:0] front_word,
  output logic signed [WW-1:0] back_word
);

  logic signed [WW-1:0] mem_a [DEPTH];
  logic signed [WW-1:0] mem_b [DEPTH];

  logic signed [WW-1:0] rd_q, fw_q, bw_q, wdata_q;
  logic                 rd_hit, fw_hit, bw_hit;

  always_ff @(posedge clk) begin
    if (accept && req.we) begin
      mem_a[req.waddr] <= req.wdata;
      mem_b[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q    <= mem_a[req.raddr];
      fw_q    <= mem_a[req.faddr];
      bw_q    <= mem_b[req.baddr];
      wdata_q <= req.wdata;
      rd_hit  <= req.we && (req.waddr == req.raddr);
      fw_hit  <= req.we && (req.waddr == req.faddr);
      bw_hit  <= req.we && (req.waddr == req.baddr);
    end
  end

  // same-step write is not yet visible in the registered read
  assign read_word  = rd_hit ? wdata_q : rd_q;
  assign front_word = fw_hit ? wdata_q : fw_q;
  assign back_word  = bw_hit ? wdata_q : bw_q;

endmodule

// ===== hw/rtl/deq_out.sv =====
// result register: masks invalid words and packs the output word
`timescale 1ns / 1ps

module deq_out import deq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 s1_valid,
  input  deq_meta_t            meta,
  input  logic signed [WW-1:0] read_word,
  input  logic signed [WW-1:0] front_word,
  input  logic signed [WW-1:0] back_word,
  output logic                 m_tvalid,
  output logic [OUT_TDW-1:0]   m_tdata
);

  logic signed [WW-1:0] rd_m, fw_m, bw_m;

  assign rd_m = meta.rd_ok    ? read_word  : '0;
  assign fw_m = meta.nonempty ? front_word : '0;
  assign bw_m = meta.nonempty ? back_word  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(OUT_TDW - OUT_BITS)'(0), meta.status, meta.count, bw_m, fw_m, rd_m};
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// top level of the bounded double-ended queue
`timescale 1ns / 1ps

// bounded double-ended queue of signed 32-bit words, 64 entries
// slave channel s_*: one request word per handshake (push back/front,
//   pop back/front, or read at a position counted from the front)
// master channel m_*: exactly one result word per request, in order,
//   with the read word, front and back words and count after the step,
//   and a status (ok, full push dropped, empty pop ignored, out of range)
// result path: the stage-one register captures the step at the accepting edge,
//   and the result register takes it over when it can take a new word
// throughput: one request per cycle while s_tready is high; the pointer/count
//   update and the memory write finish at the accepting edge, so the next
//   request sees the new state at once
// a full result register is drained and refilled in the same cycle, and
//   s_tready drops only when both stages hold words the receiver has not taken
// reset: synchronous, clears the front pointer and count (queue empty) and both
//   valid flags; the entry memory is not cleared and needs no clearing pass
// stall: with m_tready low, both stages hold and s_tready falls once full
module double_ended_queue import deq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // operation [2:0], item_value [34:3], item_position [40:35], zero fill
  input  logic [IN_TDW-1:0]  s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // read_word [31:0], front_word [63:32], back_word [95:64],
  // entry_count [102:96], status [104:103], zero fill
  output logic [OUT_TDW-1:0] m_tdata
);

  logic                 accept;
  logic                 adv;
  logic                 s1_valid;
  deq_mem_req_t         req;
  deq_meta_t            meta;
  logic signed [WW-1:0] read_word, front_word, back_word;

  // unpacked request fields
  logic [OPW-1:0]       operation;
  logic signed [WW-1:0] item_value;
  logic [PW-1:0]        item_position;

  assign operation     = s_tdata[OPW-1:0];
  assign item_value    = s_tdata[OPW+WW-1:OPW];
  assign item_position = s_tdata[OPW+WW+PW-1:OPW+WW];

  // result register can take a new word this cycle
  assign adv      = !m_tvalid || m_tready;
  // stage one can take a request if empty or moving on
  assign s_tready = !s1_valid || adv;
  assign accept   = s_tvalid && s_tready;

  deq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .adv           (adv),
    .operation     (operation),
    .item_value    (item_value),
    .item_position (item_position),
    .req           (req),
    .meta          (meta),
    .s1_valid      (s1_valid)
  );

  deq_store u_store (
    .clk        (clk),
    .accept     (accept),
    .req        (req),
    .read_word  (read_word),
    .front_word (front_word),
    .back_word  (back_word)
  );

  deq_out u_out (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .meta       (meta),
    .read_word  (read_word),
    .front_word (front_word),
    .back_word  (back_word),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata)
  );

endmodule
